// File: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CMD_W    = 2;
   localparam int ID_W     = 16;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_POP     = 2'd2,
      CMD_REQUEUE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_REMOVE,
      ST_INSERT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic find;
      logic front;
      logic remove;
      logic capture;
      logic insert;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic found;
      logic empty;
      logic full;
   } stat_type;

endpackage

// File: hdl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if
// Command channel of the priority queue: valid/ready with command payload.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic                       valid;
   logic                       ready;
   logic [spq_pkg::CMD_W-1:0]  cmd;
   logic [spq_pkg::ID_W-1:0]   item_id;
   logic [spq_pkg::PRIO_W-1:0] priority_req;

   modport source (output valid, cmd, item_id, priority_req, input ready);
   modport sink (input valid, cmd, item_id, priority_req, output ready);
endinterface

// File: hdl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if
// Result channel of the priority queue: valid/ready with result payload.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spq_pkg::STATUS_W-1:0] status;
   logic [spq_pkg::ID_W-1:0]     out_id;
   logic [spq_pkg::PRIO_W-1:0]   out_priority;
   logic [spq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, status, out_id, out_priority, occupancy, input ready);
   modport sink (input valid, status, out_id, out_priority, occupancy, output ready);
endinterface

// File: hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: search, shift out, shift in, then hand over the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [spq_pkg::CMD_W-1:0]    req_cmd,
   output logic                         req_ready,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [spq_pkg::STATUS_W-1:0] rsp_status,
   input  spq_pkg::stat_type            stat,
   output spq_pkg::ctl_type             ctl
);

   spq_pkg::state_type  state_ff, state_in;
   spq_pkg::cmd_type    cmd_ff;
   spq_pkg::status_type code_ff, code_in;
   spq_pkg::status_type rsp_status_ff;
   logic                rsp_valid_ff;
   logic                out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spq_pkg::ST_IDLE:   if (req_valid) state_in = spq_pkg::ST_FIND;
         spq_pkg::ST_FIND:   state_in = spq_pkg::ST_REMOVE;
         spq_pkg::ST_REMOVE: state_in = spq_pkg::ST_INSERT;
         spq_pkg::ST_INSERT: state_in = spq_pkg::ST_FINISH;
         spq_pkg::ST_FINISH: if (out_free) state_in = spq_pkg::ST_IDLE;
         default:            state_in = spq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      code_in   = code_ff;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            req_ready = !reset;
            ctl.load  = req_valid && !reset;
         end
         spq_pkg::ST_FIND: begin
            ctl.find  = 1'b1;
            ctl.front = (cmd_ff == spq_pkg::CMD_POP);
         end
         spq_pkg::ST_REMOVE: begin
            ctl.remove  = (cmd_ff != spq_pkg::CMD_INSERT) && stat.found;
            ctl.capture = ctl.remove && (cmd_ff inside {spq_pkg::CMD_REMOVE, spq_pkg::CMD_POP});
            code_in     = spq_pkg::STATUS_OK;
            if (cmd_ff inside {spq_pkg::CMD_REMOVE, spq_pkg::CMD_POP}) begin
               if (stat.empty) code_in = spq_pkg::STATUS_EMPTY;
               else if (!stat.found) code_in = spq_pkg::STATUS_NOT_FOUND;
            end
         end
         spq_pkg::ST_INSERT: begin
            if (cmd_ff inside {spq_pkg::CMD_INSERT, spq_pkg::CMD_REQUEUE}) begin
               ctl.insert = !stat.full;
               if (stat.full) code_in = spq_pkg::STATUS_FULL;
            end
         end
         spq_pkg::ST_FINISH: begin
            ctl.finish = out_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ctl.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      if (ctl.load) cmd_ff <= spq_pkg::cmd_type'(req_cmd);
      if (ctl.finish) rsp_status_ff <= code_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: hdl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Shifting cell array of sorted entries with id search and result register.
// ----------------------------------------------------------------------------
module spq_dpath #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [spq_pkg::ID_W-1:0]   req_item_id,
   input  logic [spq_pkg::PRIO_W-1:0] req_priority,
   input  spq_pkg::ctl_type           ctl,
   output spq_pkg::stat_type          stat,
   output logic [spq_pkg::ID_W-1:0]   rsp_out_id,
   output logic [spq_pkg::PRIO_W-1:0] rsp_out_priority,
   output logic [spq_pkg::OCC_W-1:0]  rsp_occupancy
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LG = $clog2(QUEUE_DEPTH);

   logic [spq_pkg::ID_W-1:0]   id_ff   [QUEUE_DEPTH];
   logic [spq_pkg::ID_W-1:0]   id_in   [QUEUE_DEPTH];
   logic [spq_pkg::PRIO_W-1:0] prio_ff [QUEUE_DEPTH];
   logic [spq_pkg::PRIO_W-1:0] prio_in [QUEUE_DEPTH];
   logic [CW-1:0]              count_ff, count_in;
   logic [spq_pkg::ID_W-1:0]   key_id_ff;
   logic [spq_pkg::PRIO_W-1:0] key_prio_ff;
   logic [QUEUE_DEPTH-1:0]     mask_ff, mask_in;
   logic                       found_ff, found_in;
   logic [QUEUE_DEPTH-1:0]     match, prefix, first, gt, gt_prev, at;
   logic [spq_pkg::ID_W-1:0]   sel_id;
   logic [spq_pkg::PRIO_W-1:0] sel_prio;
   logic [spq_pkg::ID_W-1:0]   cap_id_ff, out_id_ff;
   logic [spq_pkg::PRIO_W-1:0] cap_prio_ff, out_prio_ff;
   logic [spq_pkg::OCC_W-1:0]  occ_ff;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         match[i] = (count_ff > CW'(i)) && (id_ff[i] == key_id_ff);
         gt[i]    = (count_ff > CW'(i)) && (prio_ff[i] > key_prio_ff);
      end
      prefix = match;
      for (int k = 0; k < LG; k++) begin
         prefix = prefix | (prefix << (1 << k));
      end
      gt_prev = gt << 1;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         at[i] = (gt[i] || (count_ff == CW'(i))) && !gt_prev[i];
      end
      first = mask_ff & ~(mask_ff << 1);
   end

   always_comb begin
      sel_id   = '0;
      sel_prio = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         sel_id   = sel_id | (id_ff[i] & {spq_pkg::ID_W{first[i]}});
         sel_prio = sel_prio | (prio_ff[i] & {spq_pkg::PRIO_W{first[i]}});
      end
   end

   always_comb begin
      mask_in  = mask_ff;
      found_in = found_ff;
      if (ctl.find) begin
         if (ctl.front) begin
            mask_in  = '1;
            found_in = (count_ff != '0);
         end else begin
            mask_in  = prefix;
            found_in = |match;
         end
      end
   end

   always_comb begin
      id_in    = id_ff;
      prio_in  = prio_ff;
      count_in = count_ff;
      if (ctl.remove) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (mask_ff[i]) begin
               id_in[i]   = id_ff[i + 1];
               prio_in[i] = prio_ff[i + 1];
            end
         end
         count_in = count_ff - CW'(1);
      end else if (ctl.insert) begin
         if (at[0]) begin
            id_in[0]   = key_id_ff;
            prio_in[0] = key_prio_ff;
         end
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (at[i]) begin
               id_in[i]   = key_id_ff;
               prio_in[i] = key_prio_ff;
            end else if (gt_prev[i]) begin
               id_in[i]   = id_ff[i - 1];
               prio_in[i] = prio_ff[i - 1];
            end
         end
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      prio_ff  <= prio_in;
      mask_ff  <= mask_in;
      found_ff <= found_in;
      if (ctl.load) begin
         key_id_ff   <= req_item_id;
         key_prio_ff <= req_priority;
         cap_id_ff   <= '0;
         cap_prio_ff <= '0;
      end else if (ctl.capture) begin
         cap_id_ff   <= sel_id;
         cap_prio_ff <= sel_prio;
      end
      if (ctl.finish) begin
         out_id_ff   <= cap_id_ff;
         out_prio_ff <= cap_prio_ff;
         occ_ff      <= spq_pkg::OCC_W'(count_ff);
      end
   end

   assign stat.found = found_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(QUEUE_DEPTH));

   assign rsp_out_id       = out_id_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

// File: hdl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted priority queue of (id, priority) entries, ties kept in arrival order.
//
//   channel   direction  payload
//   req_chan  in         cmd, item_id, priority_req
//   rsp_chan  out        status, out_id, out_priority, occupancy
//
// Each item passes through accept, id search, shift-out, shift-in and result
// load in turn; the next item is accepted only after result load.
// The result sits in an output register; a new item is accepted while it waits.
// A stalled result holds the sequencer in its last step until taken.
// Reset empties the queue at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   spq_pkg::ctl_type  ctl;
   spq_pkg::stat_type stat;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_cmd    (req_chan.cmd),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_status (rsp_chan.status),
      .stat       (stat),
      .ctl        (ctl)
   );

   spq_dpath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_item_id      (req_chan.item_id),
      .req_priority     (req_chan.priority_req),
      .ctl              (ctl),
      .stat             (stat),
      .rsp_out_id       (rsp_chan.out_id),
      .rsp_out_priority (rsp_chan.out_priority),
      .rsp_occupancy    (rsp_chan.occupancy)
   );

   a_no_shift_conflict: assert property (@(posedge clock) disable iff (reset)
      !(ctl.remove && ctl.insert))
      else $error("remove and insert in the same cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("item accepted while busy");

   a_error_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != spq_pkg::STATUS_OK))
         |-> (rsp_chan.out_id == '0) && (rsp_chan.out_priority == '0))
      else $error("error result carries an entry");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |-> !stat.full)
      else $error("insert into a full queue");

endmodule

// File: sim/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches the command and result channels of the priority queue. Keeps its own
// sorted list of held entries, works out the result that each accepted command
// must give, and compares every accepted result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module spq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   spq_req_if          req_chan,
   spq_rsp_if          rsp_chan,
   input  logic        end_check,
   output int unsigned fail_count
);

   typedef struct packed {
      spq_pkg::status_type          status;
      logic [spq_pkg::ID_W-1:0]     out_id;
      logic [spq_pkg::PRIO_W-1:0]   out_priority;
      logic [spq_pkg::OCC_W-1:0]    occupancy;
   } queue_result_type;

   logic [spq_pkg::ID_W-1:0]   held_id   [QUEUE_DEPTH];
   logic [spq_pkg::PRIO_W-1:0] held_prio [QUEUE_DEPTH];
   int unsigned                held_count;
   queue_result_type           pending_results [$];
   int unsigned                result_index;

   initial begin
      fail_count   = 0;
      held_count   = 0;
      result_index = 0;
   end

   task automatic report_fault(string msg);
      $display("spq_checker: %s", msg);
      fail_count++;
   endtask

   function automatic int unsigned find_front(logic [spq_pkg::ID_W-1:0] id);
      for (int unsigned i = 0; i < held_count; i++) begin
         if (held_id[i] == id) return i;
      end
      return held_count;
   endfunction

   function automatic void drop_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < held_count; i++) begin
         held_id[i]   = held_id[i+1];
         held_prio[i] = held_prio[i+1];
      end
      held_count--;
   endfunction

   function automatic void place_sorted(logic [spq_pkg::ID_W-1:0] id,
                                        logic [spq_pkg::PRIO_W-1:0] prio);
      int unsigned pos;
      pos = 0;
      while (pos < held_count && held_prio[pos] <= prio) pos++;
      for (int unsigned i = held_count; i > pos; i--) begin
         held_id[i]   = held_id[i-1];
         held_prio[i] = held_prio[i-1];
      end
      held_id[pos]   = id;
      held_prio[pos] = prio;
      held_count++;
   endfunction

   function automatic queue_result_type predict_result(spq_pkg::cmd_type cmd,
                                                       logic [spq_pkg::ID_W-1:0] id,
                                                       logic [spq_pkg::PRIO_W-1:0] prio);
      queue_result_type res;
      int unsigned      pos;
      res = '{spq_pkg::STATUS_OK, '0, '0, '0};
      case (cmd)
         spq_pkg::CMD_INSERT: begin
            if (held_count >= QUEUE_DEPTH) res.status = spq_pkg::STATUS_FULL;
            else place_sorted(id, prio);
         end
         spq_pkg::CMD_REMOVE: begin
            if (held_count == 0) begin
               res.status = spq_pkg::STATUS_EMPTY;
            end else begin
               pos = find_front(id);
               if (pos >= held_count) begin
                  res.status = spq_pkg::STATUS_NOT_FOUND;
               end else begin
                  res.out_id       = held_id[pos];
                  res.out_priority = held_prio[pos];
                  drop_at(pos);
               end
            end
         end
         spq_pkg::CMD_POP: begin
            if (held_count == 0) begin
               res.status = spq_pkg::STATUS_EMPTY;
            end else begin
               res.out_id       = held_id[0];
               res.out_priority = held_prio[0];
               drop_at(0);
            end
         end
         default: begin
            pos = find_front(id);
            if (pos < held_count) drop_at(pos);
            if (held_count >= QUEUE_DEPTH) res.status = spq_pkg::STATUS_FULL;
            else place_sorted(id, prio);
         end
      endcase
      res.occupancy = held_count[spq_pkg::OCC_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         held_count = 0;
         pending_results.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               report_fault($sformatf("result %0d: item with no command outstanding",
                                      result_index));
            end else begin
               want = pending_results.pop_front();
               if (rsp_chan.status !== want.status)
                  report_fault($sformatf("result %0d: status expected %0d, got %0d",
                                         result_index, want.status, rsp_chan.status));
               if (rsp_chan.out_id !== want.out_id)
                  report_fault($sformatf("result %0d: out_id expected 0x%0h, got 0x%0h",
                                         result_index, want.out_id, rsp_chan.out_id));
               if (rsp_chan.out_priority !== want.out_priority)
                  report_fault($sformatf("result %0d: out_priority expected 0x%0h, got 0x%0h",
                                         result_index, want.out_priority,
                                         rsp_chan.out_priority));
               if (rsp_chan.occupancy !== want.occupancy)
                  report_fault($sformatf("result %0d: occupancy expected %0d, got %0d",
                                         result_index, want.occupancy, rsp_chan.occupancy));
            end
            result_index++;
         end
         if (req_chan.valid && req_chan.ready)
            pending_results.push_back(predict_result(spq_pkg::cmd_type'(req_chan.cmd),
                                                     req_chan.item_id,
                                                     req_chan.priority_req));
         if (end_check && pending_results.size() != 0) begin
            report_fault($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
         end
      end
   end

endmodule

// File: sim/tb_stable_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Drives commands into the priority queue: a directed pass over empty, full,
// duplicate-id and tie cases, then random fill and drain runs over small id
// and priority pools, under three idling profiles and long result stalls.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;

   localparam int QUEUE_DEPTH  = 16;
   localparam int PHASE_ITEMS  = 217;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int ID_W         = spq_pkg::ID_W;
   localparam int PRIO_W       = spq_pkg::PRIO_W;

   logic        clock;
   logic        reset;
   logic        end_check;
   int unsigned fail_count;
   int unsigned sent_count;
   int unsigned got_count;
   int unsigned cycle_count;
   int unsigned hold_left;
   int unsigned send_idle_pct;
   int unsigned rcv_idle_pct;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   stable_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .end_check  (end_check),
      .fail_count (fail_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // hold off the result channel for a long stretch twice in the run
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) got_count++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rsp_chan.valid && rsp_chan.ready &&
                      (got_count == 40 || got_count == 400)) begin
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   task automatic send_item(spq_pkg::cmd_type cmd, logic [ID_W-1:0] id,
                            logic [PRIO_W-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= cmd;
      req_chan.item_id      <= id;
      req_chan.priority_req <= prio;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   initial begin
      logic [ID_W-1:0]   id_pool   [8];
      logic [PRIO_W-1:0] prio_pool [4];
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      spq_pkg::cmd_type  cmd;
      bit                filling;
      int unsigned       roll;

      clock                 = 1'b0;
      reset                 = 1'b1;
      end_check             = 1'b0;
      sent_count            = 0;
      got_count             = 0;
      cycle_count           = 0;
      hold_left             = 0;
      req_chan.valid        = 1'b0;
      req_chan.cmd          = spq_pkg::CMD_INSERT;
      req_chan.item_id      = '0;
      req_chan.priority_req = '0;
      rsp_chan.ready        = 1'b0;
      send_idle_pct         = 16;
      rcv_idle_pct          = 74;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(spq_pkg::CMD_POP, 16'h0000, 8'h00);
      send_item(spq_pkg::CMD_REMOVE, 16'hFFFF, 8'hFF);
      send_item(spq_pkg::CMD_INSERT, 16'h0000, 8'hFF);
      send_item(spq_pkg::CMD_INSERT, 16'hFFFF, 8'h00);
      send_item(spq_pkg::CMD_INSERT, 16'h1234, 8'h80);
      send_item(spq_pkg::CMD_INSERT, 16'h1234, 8'h80);
      send_item(spq_pkg::CMD_INSERT, 16'hA5A5, 8'h80);
      send_item(spq_pkg::CMD_INSERT, 16'h5A5A, 8'h7F);
      for (int i = 0; i < 10; i++)
         send_item(spq_pkg::CMD_INSERT, 16'h0100 + 16'(i), 8'(i * 29));
      send_item(spq_pkg::CMD_INSERT, 16'h7777, 8'h10);
      send_item(spq_pkg::CMD_REQUEUE, 16'h7777, 8'h10);
      send_item(spq_pkg::CMD_REQUEUE, 16'hFFFF, 8'hFF);
      send_item(spq_pkg::CMD_REMOVE, 16'hBEEF, 8'h00);
      send_item(spq_pkg::CMD_REMOVE, 16'h1234, 8'h00);
      send_item(spq_pkg::CMD_POP, 16'h0000, 8'h00);
      send_item(spq_pkg::CMD_REQUEUE, 16'h4321, 8'h00);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 16;
               rcv_idle_pct  = 74;
            end
            1: begin
               send_idle_pct = 74;
               rcv_idle_pct  = 16;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 32 == 0) begin
               filling = 1'($urandom_range(1));
               foreach (id_pool[k]) id_pool[k] = ID_W'($urandom);
               foreach (prio_pool[k]) prio_pool[k] = PRIO_W'($urandom);
            end
            roll = $urandom_range(99);
            if (n % 32 >= 29)
               cmd = spq_pkg::cmd_type'($urandom_range(3));
            else if (filling)
               cmd = roll < 55 ? spq_pkg::CMD_INSERT : roll < 75 ? spq_pkg::CMD_REQUEUE :
                     roll < 87 ? spq_pkg::CMD_REMOVE : spq_pkg::CMD_POP;
            else
               cmd = roll < 15 ? spq_pkg::CMD_INSERT : roll < 25 ? spq_pkg::CMD_REQUEUE :
                     roll < 60 ? spq_pkg::CMD_REMOVE : spq_pkg::CMD_POP;
            id = ($urandom_range(3) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(7)];
            case ($urandom_range(3))
               0: prio = PRIO_W'($urandom);
               1: prio = $urandom_range(1) ? 8'hFF : 8'h00;
               default: prio = prio_pool[$urandom_range(3)];
            endcase
            send_item(cmd, id, prio);
         end
      end
      req_chan.valid <= 1'b0;

      wait (got_count == sent_count);
      repeat (10) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/spq_pkg.sv
hdl/spq_req_if.sv
hdl/spq_rsp_if.sv
hdl/spq_ctrl.sv
hdl/spq_dpath.sv
hdl/stable_priority_queue.sv
sim/spq_checker.sv
sim/tb_stable_priority_queue.sv
